// ----- design/pidpc_pkg.sv -----
package pidpc_pkg;

    // Filter and datapath widths
    localparam int AVERAGE_TAPS = 4;
    localparam int HIST_DEPTH   = AVERAGE_TAPS - 1;
    localparam int POS_W        = 16;
    localparam int SUM_W        = POS_W + $clog2(AVERAGE_TAPS);
    localparam int ERR_W        = 20;
    localparam int DIFF_W       = ERR_W + 1;
    localparam int INTEG_W      = 48;

    // Gain multiplier split
    localparam int GAIN_W       = 40;
    localparam int GAIN_LO_W    = 20;
    localparam int OP_LO_W      = 24;
    localparam int PROD_W       = GAIN_W + INTEG_W;

    // Control value scaling
    localparam int ACC_W        = PROD_W + 2;
    localparam int CV_SHIFT     = 10;
    localparam int SHIFTED_W    = ACC_W - CV_SHIFT;
    localparam int CV_W         = 32;

    // Duty mapping
    localparam int MAG_W        = 19;
    localparam int SCALED_W     = MAG_W + 6;
    localparam int DUTY_W       = 8;
    localparam int DUTY_FRAC    = 16;
    localparam int DUTY_BASE    = 15;
    localparam int DUTY_FULL    = 255;

    // Pipeline depth, from input register to output register
    localparam int N_STAGES     = 6;

    localparam logic signed [CV_W-1:0] CV_MAX         = 32'sh7FFF_FFFF;
    localparam logic signed [CV_W-1:0] CV_MIN         = 32'sh8000_0000;
    localparam logic signed [CV_W-1:0] CV_FIVE_V      = 32'sd327680;
    localparam logic signed [CV_W-1:0] CV_NEG_FIVE_V  = -32'sd327680;

    localparam logic signed [GAIN_W-1:0] KP_RESET = 40'sd10905190;
    localparam logic signed [GAIN_W-1:0] KI_RESET = 40'sd881;
    localparam logic signed [GAIN_W-1:0] KD_RESET = 40'sd9395240960;

    localparam int CFG_IDX_W = 2;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_KP_GAIN = 2'd0,
        CFG_KI_GAIN = 2'd1,
        CFG_KD_GAIN = 2'd2
    } t_cfg_idx;

    typedef struct packed {
        logic signed [POS_W-1:0] position;
        logic signed [POS_W-1:0] target;
    } t_in_item;

    typedef struct packed {
        logic [DUTY_W-1:0]      duty;
        logic                   forward;
        logic signed [CV_W-1:0] control_value;
    } t_out_item;

endpackage

// ----- design/pidpc_gain_mul.sv -----
module pidpc_gain_mul (
    input  logic                                 i_clk,
    input  logic                                 i_en_pp,
    input  logic                                 i_en_sum,
    input  logic signed [pidpc_pkg::GAIN_W-1:0]  i_gain,
    input  logic signed [pidpc_pkg::INTEG_W-1:0] i_op,
    output logic signed [pidpc_pkg::PROD_W-1:0]  o_prod
);
    import pidpc_pkg::*;

    localparam int GAIN_HI_W = GAIN_W - GAIN_LO_W;
    localparam int OP_HI_W   = INTEG_W - OP_LO_W;
    localparam int PP_LL_W   = GAIN_LO_W + OP_LO_W + 2;
    localparam int PP_LH_W   = GAIN_LO_W + 1 + OP_HI_W;
    localparam int PP_HL_W   = GAIN_HI_W + OP_LO_W + 1;
    localparam int PP_HH_W   = GAIN_HI_W + OP_HI_W;

    logic signed [GAIN_LO_W:0]   w_gain_lo;
    logic signed [GAIN_HI_W-1:0] w_gain_hi;
    logic signed [OP_LO_W:0]     w_op_lo;
    logic signed [OP_HI_W-1:0]   w_op_hi;

    logic signed [PP_LL_W-1:0] r_pp_ll;
    logic signed [PP_LH_W-1:0] r_pp_lh;
    logic signed [PP_HL_W-1:0] r_pp_hl;
    logic signed [PP_HH_W-1:0] r_pp_hh;
    logic signed [PROD_W-1:0]  n_prod;
    logic signed [PROD_W-1:0]  r_prod;

    // Split both operands: low halves as unsigned, high halves signed
    assign w_gain_lo = $signed({1'b0, i_gain[GAIN_LO_W-1:0]});
    assign w_gain_hi = i_gain[GAIN_W-1:GAIN_LO_W];
    assign w_op_lo   = $signed({1'b0, i_op[OP_LO_W-1:0]});
    assign w_op_hi   = i_op[INTEG_W-1:OP_LO_W];

    // Register the four partial products
    always_ff @(posedge i_clk) begin
        if (i_en_pp) begin
            r_pp_ll <= PP_LL_W'(w_gain_lo * w_op_lo);
            r_pp_lh <= PP_LH_W'(w_gain_lo * w_op_hi);
            r_pp_hl <= PP_HL_W'(w_gain_hi * w_op_lo);
            r_pp_hh <= PP_HH_W'(w_gain_hi * w_op_hi);
        end
    end

    // Align and combine the partial products
    always_comb begin
        n_prod = PROD_W'(r_pp_ll)
               + (PROD_W'(r_pp_lh) <<< OP_LO_W)
               + (PROD_W'(r_pp_hl) <<< GAIN_LO_W)
               + (PROD_W'(r_pp_hh) <<< (GAIN_LO_W + OP_LO_W));
    end

    always_ff @(posedge i_clk) begin
        if (i_en_sum) begin
            r_prod <= n_prod;
        end
    end

    assign o_prod = r_prod;

endmodule

// ----- design/pid_position_pwm_controller_core.sv -----
// PID position controller with a four-tap moving-average position filter and
// PWM duty mapping.
// Input channel (i_in_valid / o_in_ready, i_in_item): one transfer per sample,
// carrying the encoder position and the target position.
// Output channel (o_out_valid / i_out_ready, o_out_item): one transfer per
// sample, carrying the PWM duty, the direction bit and the Q16.16 control value.
// Config channel (i_cfg_valid / o_cfg_ready, i_cfg_index, i_cfg_data): writes
// kp, ki or kd; always ready. Write only while no sample is in flight.
// Throughput is one sample per cycle while the receiver is ready; the six
// register stages are error, integral and difference, partial products, gain
// products, saturated control value, and the output register.
// When the receiver stalls, each stage holds only while the stage after it is
// full, so empty stages keep taking samples until the pipeline is full.
// Reset clears the history, integral, last error and all stage valid flags,
// and loads the default gains.
module pid_position_pwm_controller_core (
    input  logic                                      i_clk,
    input  logic                                      i_rst_n,
    input  logic                                      i_in_valid,
    output logic                                      o_in_ready,
    input  pidpc_pkg::t_in_item                       i_in_item,
    output logic                                      o_out_valid,
    input  logic                                      i_out_ready,
    output pidpc_pkg::t_out_item                      o_out_item,
    input  logic                                      i_cfg_valid,
    output logic                                      o_cfg_ready,
    input  logic [pidpc_pkg::CFG_IDX_W-1:0]           i_cfg_index,
    input  logic [pidpc_pkg::GAIN_W-1:0]              i_cfg_data
);
    import pidpc_pkg::*;

    localparam int ST_ERR   = 0;
    localparam int ST_INTEG = 1;
    localparam int ST_PP    = 2;
    localparam int ST_PROD  = 3;
    localparam int ST_CV    = 4;
    localparam int ST_OUT   = 5;

    // Gains
    logic signed [GAIN_W-1:0] r_kp;
    logic signed [GAIN_W-1:0] r_ki;
    logic signed [GAIN_W-1:0] r_kd;

    // Pipeline flow control
    logic [N_STAGES-1:0] r_vld;
    logic [N_STAGES-1:0] w_rdy;
    logic [N_STAGES-1:0] w_up_vld;
    logic [N_STAGES-1:0] w_load;

    // Controller state
    logic signed [POS_W-1:0]   r_hist [HIST_DEPTH];
    logic signed [INTEG_W-1:0] r_integ;
    logic signed [ERR_W-1:0]   r_last_err;

    // Stage payloads
    logic signed [SUM_W-1:0]     n_sum;
    logic signed [ERR_W-1:0]     n_err;
    logic signed [ERR_W-1:0]     r0_err;
    logic signed [INTEG_W:0]     n_integ_sum;
    logic signed [INTEG_W-1:0]   n_integ;
    logic signed [DIFF_W-1:0]    n_diff;
    logic signed [DIFF_W-1:0]    r1_diff;
    logic signed [PROD_W-1:0]    w_prod_p;
    logic signed [PROD_W-1:0]    w_prod_i;
    logic signed [PROD_W-1:0]    w_prod_d;
    logic signed [ACC_W-1:0]     n_acc;
    logic signed [SHIFTED_W-1:0] n_shifted;
    logic [SHIFTED_W-CV_W:0]     w_upper;
    logic signed [CV_W-1:0]      n_cv;
    logic signed [CV_W-1:0]      r4_cv;
    logic [CV_W-1:0]             n_neg_cv;
    logic [MAG_W-1:0]            n_mag;
    logic [SCALED_W-1:0]         n_scaled;
    t_out_item                   n_out;
    t_out_item                   r_out;

    // Configuration writes
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_kp <= KP_RESET;
            r_ki <= KI_RESET;
            r_kd <= KD_RESET;
        end else if (i_cfg_valid) begin
            unique case (t_cfg_idx'(i_cfg_index))
                CFG_KP_GAIN: r_kp <= i_cfg_data;
                CFG_KI_GAIN: r_ki <= i_cfg_data;
                CFG_KD_GAIN: r_kd <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // Each stage advances when empty or when the stage after it moves on
    always_comb begin
        w_rdy[N_STAGES-1] = !r_vld[N_STAGES-1] || i_out_ready;
        for (int k = N_STAGES - 2; k >= 0; k--) begin
            w_rdy[k] = !r_vld[k] || w_rdy[k+1];
        end
    end

    assign w_up_vld   = {r_vld[N_STAGES-2:0], i_in_valid};
    assign w_load     = w_up_vld & w_rdy;
    assign o_in_ready = w_rdy[ST_ERR];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            r_vld <= (w_rdy & w_up_vld) | (~w_rdy & r_vld);
        end
    end

    // Moving-average sum and error in fractional counts
    always_comb begin
        n_sum = SUM_W'(i_in_item.position);
        for (int i = 0; i < HIST_DEPTH; i++) begin
            n_sum = n_sum + SUM_W'(r_hist[i]);
        end
        n_err = ERR_W'(i_in_item.target) * ERR_W'(AVERAGE_TAPS) - ERR_W'(n_sum);
    end

    // Shift the position history on each input transfer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < HIST_DEPTH; i++) begin
                r_hist[i] <= '0;
            end
        end else if (w_load[ST_ERR]) begin
            r_hist[0] <= i_in_item.position;
            for (int i = 1; i < HIST_DEPTH; i++) begin
                r_hist[i] <= r_hist[i-1];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_load[ST_ERR]) begin
            r0_err <= n_err;
        end
    end

    // Saturating integral and error difference
    always_comb begin
        n_integ_sum = (INTEG_W+1)'(r_integ) + (INTEG_W+1)'(r0_err);
        priority if (n_integ_sum[INTEG_W] == n_integ_sum[INTEG_W-1]) begin
            n_integ = n_integ_sum[INTEG_W-1:0];
        end else if (n_integ_sum[INTEG_W]) begin
            n_integ = {1'b1, {(INTEG_W-1){1'b0}}};
        end else begin
            n_integ = {1'b0, {(INTEG_W-1){1'b1}}};
        end
        n_diff = DIFF_W'(r0_err) - DIFF_W'(r_last_err);
    end

    // The integral and last error double as this stage's payload
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_integ    <= '0;
            r_last_err <= '0;
        end else if (w_load[ST_INTEG]) begin
            r_integ    <= n_integ;
            r_last_err <= r0_err;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_load[ST_INTEG]) begin
            r1_diff <= n_diff;
        end
    end

    // Gain products over two stages
    pidpc_gain_mul u_mul_p (
        .i_clk    (i_clk),
        .i_en_pp  (w_load[ST_PP]),
        .i_en_sum (w_load[ST_PROD]),
        .i_gain   (r_kp),
        .i_op     (INTEG_W'(r_last_err)),
        .o_prod   (w_prod_p)
    );

    pidpc_gain_mul u_mul_i (
        .i_clk    (i_clk),
        .i_en_pp  (w_load[ST_PP]),
        .i_en_sum (w_load[ST_PROD]),
        .i_gain   (r_ki),
        .i_op     (r_integ),
        .o_prod   (w_prod_i)
    );

    pidpc_gain_mul u_mul_d (
        .i_clk    (i_clk),
        .i_en_pp  (w_load[ST_PP]),
        .i_en_sum (w_load[ST_PROD]),
        .i_gain   (r_kd),
        .i_op     (INTEG_W'(r1_diff)),
        .o_prod   (w_prod_d)
    );

    // Sum the terms, drop ten fraction bits and saturate to 32 bits
    always_comb begin
        n_acc     = ACC_W'(w_prod_p) + ACC_W'(w_prod_i) + ACC_W'(w_prod_d);
        n_shifted = n_acc[ACC_W-1:CV_SHIFT];
        w_upper   = n_shifted[SHIFTED_W-1:CV_W-1];
        priority if (&w_upper || ~|w_upper) begin
            n_cv = n_shifted[CV_W-1:0];
        end else if (n_shifted[SHIFTED_W-1]) begin
            n_cv = CV_MIN;
        end else begin
            n_cv = CV_MAX;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_load[ST_CV]) begin
            r4_cv <= n_cv;
        end
    end

    // Map the control value to duty and direction
    always_comb begin
        n_neg_cv = -r4_cv;
        n_mag    = r4_cv[CV_W-1] ? n_neg_cv[MAG_W-1:0] : r4_cv[MAG_W-1:0];
        n_scaled = SCALED_W'({n_mag, 5'b0}) + SCALED_W'({n_mag, 4'b0});
        n_out.control_value = r4_cv;
        priority if (r4_cv >= CV_FIVE_V) begin
            n_out.duty    = DUTY_W'(DUTY_FULL);
            n_out.forward = 1'b1;
        end else if (r4_cv <= CV_NEG_FIVE_V) begin
            n_out.duty    = DUTY_W'(DUTY_FULL);
            n_out.forward = 1'b0;
        end else begin
            n_out.duty    = DUTY_W'(DUTY_BASE) + n_scaled[DUTY_FRAC +: DUTY_W];
            n_out.forward = !r4_cv[CV_W-1];
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_load[ST_OUT]) begin
            r_out <= n_out;
        end
    end

    assign o_out_valid = r_vld[ST_OUT];
    assign o_out_item  = r_out;

endmodule

// ----- design/pidpc_checker.sv -----
module pidpc_checker (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            o_out_valid,
    input  logic                            i_out_ready,
    input  pidpc_pkg::t_out_item            o_out_item
);
    import pidpc_pkg::*;

    // Hold a stalled result
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid && $stable(o_out_item))
        else $error("stalled result dropped or changed");

    // No result right after reset
    a_reset_empty: assert property (@(posedge i_clk)
        $past(!i_rst_n) |-> !o_out_valid)
        else $error("result shown after reset");

    // Direction follows the sign of the control value
    a_forward: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> o_out_item.forward == !o_out_item.control_value[CV_W-1])
        else $error("direction does not match control value sign");

    // Full duty at or beyond five volts, at least the base duty otherwise
    a_duty_sat: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && (o_out_item.control_value >= CV_FIVE_V ||
                        o_out_item.control_value <= CV_NEG_FIVE_V)
        |-> o_out_item.duty == DUTY_W'(DUTY_FULL))
        else $error("saturated control value without full duty");

    a_duty_min: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> o_out_item.duty >= DUTY_W'(DUTY_BASE))
        else $error("duty below base value");

endmodule

bind pid_position_pwm_controller_core pidpc_checker u_pidpc_checker (.*);
